@@ rtl/core/ascending_sort_engine_assert.svh @@
// Assertion macros for the ascending sort engine.
// Included by the top level; expects clk and arst_n in scope.
`ifndef ASCENDING_SORT_ENGINE_ASSERT_SVH
`define ASCENDING_SORT_ENGINE_ASSERT_SVH

// Checked only while out of reset.
`define ASE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ase_pkg.sv @@
// Shared types and constants of the ascending sort engine.
// No dependencies; imported by the interfaces, the cell and the top level.
package ase_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic {
		PH_LOAD,
		PH_DRAIN
	} phase_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic  insert;
		logic  shift;
		data_t new_value;
	} cell_ctrl_t;

	// What one cell shows its neighbors.
	typedef struct packed {
		logic  valid;
		logic  lt;
		data_t value;
	} cell_link_t;

endpackage

@@ rtl/core/ase_in_if.sv @@
// Input item channel of the ascending sort engine.
// Depends on ase_pkg for the value type.
interface ase_in_if;
	import ase_pkg::*;

	logic  valid;
	logic  ready;
	data_t value;
	logic  is_last;

	modport source (output valid, output value, output is_last, input ready);
	modport sink (input valid, input value, input is_last, output ready);
endinterface

@@ rtl/core/ase_out_if.sv @@
// Result item channel of the ascending sort engine.
// Depends on ase_pkg for the value type.
interface ase_out_if;
	import ase_pkg::*;

	logic  valid;
	logic  ready;
	data_t sorted_value;
	logic  end_of_set;
	logic  truncated;

	modport source (output valid, output sorted_value, output end_of_set, output truncated,
		input ready);
	modport sink (input valid, input sorted_value, input end_of_set, input truncated,
		output ready);
endinterface

@@ rtl/core/ascending_sort_engine.sv @@
// Top level of the ascending sort engine: a chain of insertion cells.
// Depends on ase_pkg, ase_in_if, ase_out_if, ase_cell and the assertion header.
//
// Channel   Direction  Payload                                   Handshake
// items     in         value (s32), is_last                      valid/ready
// results   out        sorted_value (s32), end_of_set, truncated valid/ready
//
// Loading takes one item per cycle: every cell compares the broadcast value with its own
// in the same cycle and the chain opens a gap at the right place, so the set stays sorted.
// The item with is_last closes the set; the next cycle the chain drains from its head, one
// result per cycle while results are taken, so a set of n items gives the smaller of n and
// MAX_ITEMS results, since items that arrive on a full chain are dropped.
// Items are not taken while the chain drains. A stalled result holds in the head cell.
// Reset empties the chain at once through the cells' occupancy bits.
module ascending_sort_engine (
	input logic      clk,
	input logic      arst_n,
	ase_in_if.sink   items,
	ase_out_if.source results
);
	import ase_pkg::*;

	phase_t     phase_q;
	phase_t     phase_next;
	logic       trunc_q;
	cell_ctrl_t ctrl;
	cell_link_t link [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] occupied;
	logic       in_fire;
	logic       out_fire;
	logic       full;

	localparam cell_link_t EDGE_LINK = '{valid: 1'b0, lt: 1'b0, value: '0};

	assign in_fire  = items.valid && items.ready;
	assign out_fire = results.valid && results.ready;
	// The chain is compact from the head, so the tail cell tells whether it is full.
	assign full     = link[MAX_ITEMS-1].valid;

	assign ctrl.insert    = in_fire && !full;
	assign ctrl.shift     = out_fire;
	assign ctrl.new_value = items.value;

	// The head cell has nothing before it; the tail cell pulls in an empty slot.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		ase_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.left   ((i == 0) ? EDGE_LINK : link[(i == 0) ? 0 : i - 1]),
			.right  ((i == MAX_ITEMS - 1) ? EDGE_LINK : link[(i == MAX_ITEMS - 1) ? i : i + 1]),
			.self   (link[i])
		);
		assign occupied[i] = link[i].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOAD;
		end else begin
			phase_q <= phase_next;
		end
	end

	always_comb begin
		phase_next = phase_q;
		unique case (phase_q)
			PH_LOAD: begin
				if (in_fire && items.is_last) begin
					phase_next = PH_DRAIN;
				end
			end
			PH_DRAIN: begin
				if (out_fire && results.end_of_set) begin
					phase_next = PH_LOAD;
				end
			end
			default: phase_next = PH_LOAD;
		endcase
	end

	// Raised by any item dropped on a full chain; cleared when the set has left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trunc_q <= 1'b0;
		end else if (out_fire && results.end_of_set) begin
			trunc_q <= 1'b0;
		end else if (in_fire && full) begin
			trunc_q <= 1'b1;
		end
	end

	assign items.ready          = (phase_q == PH_LOAD);
	assign results.valid        = (phase_q == PH_DRAIN) && link[0].valid;
	assign results.sorted_value = link[0].value;
	assign results.end_of_set   = !link[1].valid;
	assign results.truncated    = trunc_q;

`include "ascending_sort_engine_assert.svh"

	`ASE_ASSERT(a_result_only_in_drain, results.valid |-> phase_q == PH_DRAIN, "result outside drain")
	`ASE_ASSERT_ALWAYS(a_chain_compact, ((occupied >> 1) & ~occupied) == '0, "gap in chain")
	`ASE_ASSERT(a_drain_never_empty, phase_q == PH_DRAIN |-> link[0].valid, "drain with empty head")
	`ASE_ASSERT(a_ascending, out_fire && !results.end_of_set |=> results.valid && (results.sorted_value >= $past(results.sorted_value)), "results out of order")
endmodule

@@ rtl/core/ase_cell.sv @@
// One cell of the insertion chain: holds one value and its occupancy bit.
// Depends on ase_pkg for the control and link structs.
module ase_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  ase_pkg::cell_ctrl_t ctrl,
	input  ase_pkg::cell_link_t left,
	input  ase_pkg::cell_link_t right,
	output ase_pkg::cell_link_t self
);
	import ase_pkg::*;

	logic  valid_q;
	data_t value_q;
	logic  lt;

	// An empty cell acts as plus infinity, so the new value always goes before it.
	assign lt = !valid_q || (ctrl.new_value < value_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right.valid;
		end else if (ctrl.insert) begin
			if (left.lt) begin
				valid_q <= left.valid;
			end else if (lt) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= right.value;
		end else if (ctrl.insert) begin
			if (left.lt) begin
				value_q <= left.value;
			end else if (lt) begin
				value_q <= ctrl.new_value;
			end
		end
	end

	assign self = '{valid: valid_q, lt: lt, value: value_q};
endmodule
